// ----- hdl/tars_pkg.sv -----
// Package for the range-sensor obstacle steering block.
// Holds the command record passed from parser to decision stage, codes and reset values.
// No dependencies.
package tars_pkg;

  // Input source codes.
  localparam logic [1:0] ACT_LEFT  = 2'd0;
  localparam logic [1:0] ACT_RIGHT = 2'd1;
  localparam logic [1:0] ACT_BACK  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_USE_BACK  = 2'd0;
  localparam logic [1:0] REG_AVOID_OFF = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_SPEED     = 2'd3;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 14;

  // Frame characters.
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam logic [2:0] DIGITS_MAX = 3'd4;

  // Back sensor codes.
  localparam logic [7:0] BACK_GO_RIGHT = 8'h01;
  localparam logic [7:0] BACK_GO_LEFT  = 8'h02;

  // Reset values.
  localparam logic [15:0] DIST_RESET      = 16'd2000;
  localparam logic [13:0] THRESHOLD_RESET = 14'd1000;
  localparam logic [6:0]  SPEED_RESET     = 7'd60;

  localparam int QueueDepth = 2;

  // One decision request from the parser.
  typedef struct packed {
    logic        is_back;   // back sensor byte, code is valid
    logic        side;      // 0 left, 1 right (range frames)
    logic        upd;       // frame carried one to four digits
    logic [15:0] value;     // decoded distance
    logic [7:0]  code;      // back sensor code
  } cmd_t;

  typedef struct packed {
    logic                 write;
    logic [CfgIndexW-1:0] index;
    logic [CfgDataW-1:0]  data;
  } cfg_wr_t;

endpackage

// ----- hdl/tars_front.sv -----
// Front end: frame parser for the two range sensors and back sensor classifier.
// Emits one decision command per completed frame or back byte. Uses tars_pkg.
module tars_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        action,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output tars_pkg::cmd_t    cmd
);
  import tars_pkg::*;

  typedef enum logic [3:0] {
    PS_CR  = 4'b0001,
    PS_LF  = 4'b0010,
    PS_DIG = 4'b0100,
    PS_M   = 4'b1000
  } parse_t;

  parse_t      pstate [2];
  logic [2:0]  count [2];
  logic [15:0] acc [2];

  parse_t      pstate_next;
  logic [2:0]  count_next;
  logic [15:0] acc_next;
  logic        side;
  logic        is_range;
  logic [15:0] acc_base;
  logic [7:0]  digit;

  assign side     = action[0];
  assign is_range = (action == ACT_LEFT) || (action == ACT_RIGHT);
  // The first digit of a frame starts the sum from zero.
  assign acc_base = (count[side] == 3'd0) ? 16'd0 : acc[side];
  assign digit    = rx_byte - CH_ZERO;

  always_comb begin
    pstate_next = pstate[side];
    count_next  = count[side];
    acc_next    = acc[side];
    push        = 1'b0;
    cmd.is_back = 1'b0;
    cmd.side    = side;
    cmd.upd     = (count[side] != 3'd0) && (count[side] <= DIGITS_MAX);
    cmd.value   = acc[side];
    cmd.code    = rx_byte;
    if (accept && action == ACT_BACK) begin
      push        = 1'b1;
      cmd.is_back = 1'b1;
    end
    unique case (pstate[side])
      PS_CR: begin
        if (rx_byte == CH_CR) begin
          pstate_next = PS_LF;
        end else begin
          count_next = 3'd0;
        end
      end
      PS_LF: begin
        if (rx_byte == CH_LF) begin
          pstate_next = PS_DIG;
        end else begin
          pstate_next = PS_CR;
          count_next  = 3'd0;
        end
      end
      PS_DIG: begin
        if (rx_byte == CH_M) begin
          pstate_next = PS_M;
        end else begin
          if (count[side] < DIGITS_MAX) begin
            acc_next = (acc_base << 3) + (acc_base << 1) + {8'd0, digit};
          end
          if (count[side] <= DIGITS_MAX) begin
            count_next = count[side] + 3'd1;
          end
        end
      end
      PS_M: begin
        pstate_next = PS_CR;
        count_next  = 3'd0;
        if (accept && is_range && rx_byte == CH_M) begin
          push = 1'b1;
        end
      end
      default: begin
        pstate_next = PS_CR;
        count_next  = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate[0] <= PS_CR;
      pstate[1] <= PS_CR;
      count[0]  <= 3'd0;
      count[1]  <= 3'd0;
    end else if (accept && is_range) begin
      pstate[side] <= pstate_next;
      count[side]  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_range) begin
      acc[side] <= acc_next;
    end
  end

endmodule

// ----- hdl/tars_queue.sv -----
// Short command queue between the parser and the decision stage.
// Circular buffer with a fill count. Uses tars_pkg.
module tars_queue #(
  parameter int QDepth = tars_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tars_pkg::cmd_t    wdata,
  input  logic              pop,
  output logic              full,
  output logic              nonempty,
  output tars_pkg::cmd_t    rdata
);
  import tars_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QDepth);

  cmd_t            mem [QDepth];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntFull);
  assign nonempty = (count != '0);
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PtrLast) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PtrLast) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CntFull)
    else $error("queue count exceeds depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("pop from empty queue");
  a_push_room: assert property (@(posedge clk) disable iff (rst) push && !pop |-> !full)
    else $error("push into full queue");

endmodule

// ----- hdl/tars_back.sv -----
// Back end: distance registers, configuration and avoidance decision with output register.
// Takes commands from tars_queue. Uses tars_pkg.
module tars_back (
  input  logic                 clk,
  input  logic                 rst,
  input  tars_pkg::cfg_wr_t    cfg,
  input  logic                 q_nonempty,
  input  tars_pkg::cmd_t       q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [7:0]    lateral_cmd,
  output logic                 obstacle_flag,
  output logic                 left_near,
  output logic                 right_near,
  output logic signed [15:0]   left_distance,
  output logic signed [15:0]   right_distance
);
  import tars_pkg::*;

  logic        use_back;
  logic        avoid_off;
  logic [13:0] threshold;
  logic [6:0]  speed;

  logic [15:0] left_dist;
  logic [15:0] right_dist;
  logic [7:0]  back_code;
  logic [7:0]  lateral;
  logic        dodge;

  logic [15:0] left_dist_next;
  logic [15:0] right_dist_next;
  logic [7:0]  back_code_next;
  logic [7:0]  lateral_next;
  logic        dodge_next;
  logic        ln;
  logic        rn;
  logic        go_pos;
  logic        go_neg;

  assign pop = q_nonempty && (!out_valid || !out_stall);

  always_comb begin
    left_dist_next  = left_dist;
    right_dist_next = right_dist;
    back_code_next  = back_code;
    if (q_data.is_back) begin
      back_code_next = q_data.code;
    end else if (q_data.upd) begin
      if (q_data.side) begin
        right_dist_next = q_data.value;
      end else begin
        left_dist_next = q_data.value;
      end
    end
    ln = $signed(left_dist_next) < $signed({2'b00, threshold});
    rn = $signed(right_dist_next) < $signed({2'b00, threshold});
    if (use_back) begin
      go_pos = (back_code_next == BACK_GO_RIGHT);
      go_neg = (back_code_next == BACK_GO_LEFT);
    end else begin
      go_pos = ln;
      go_neg = !ln && rn;
    end
    lateral_next = lateral;
    dodge_next   = 1'b0;
    if (!avoid_off) begin
      dodge_next = go_pos || go_neg;
      if (go_pos) begin
        lateral_next = {1'b0, speed};
      end else if (go_neg) begin
        lateral_next = 8'd0 - {1'b0, speed};
      end else begin
        lateral_next = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_back  <= 1'b0;
      avoid_off <= 1'b0;
      threshold <= THRESHOLD_RESET;
      speed     <= SPEED_RESET;
    end else if (cfg.write) begin
      unique case (cfg.index)
        REG_USE_BACK:  use_back  <= cfg.data[0];
        REG_AVOID_OFF: avoid_off <= cfg.data[0];
        REG_THRESHOLD: threshold <= cfg.data;
        REG_SPEED:     speed     <= cfg.data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_dist  <= DIST_RESET;
      right_dist <= DIST_RESET;
      back_code  <= 8'd0;
      lateral    <= 8'd0;
      dodge      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        left_dist  <= left_dist_next;
        right_dist <= right_dist_next;
        back_code  <= back_code_next;
        lateral    <= lateral_next;
        dodge      <= dodge_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      lateral_cmd    <= $signed(lateral_next);
      obstacle_flag  <= dodge_next;
      left_near      <= ln;
      right_near     <= rn;
      left_distance  <= $signed(left_dist_next);
      right_distance <= $signed(right_dist_next);
    end
  end

endmodule

// ----- hdl/tof_ascii_range_obstacle_steer.sv -----
// Top level of the range-sensor obstacle steering block.
// Instantiates tars_front, tars_queue and tars_back; uses tars_pkg.
//
// Use:
//   Bytes enter on the input channel (in_valid / in_stall) tagged with their
//   source in action: left range sensor, right range sensor or back sensor.
//   An item is taken at a clock edge with in_valid high and in_stall low.
//   The range sensors send frames of CR LF, one to four ASCII digits, "mm".
//   Each completed frame and each back sensor byte yields one result item on
//   the output channel (out_valid / out_stall); all other bytes yield none.
//   A result carries the sideways command, the obstacle flag, both near
//   flags and both stored distances.
// Timing:
//   The parser classifies a byte in the cycle it is taken and writes a
//   command into a two-entry queue at that same edge. The decision stage
//   takes one command per cycle into the output register unless a held
//   result blocks it, so a result passes the queue and then the output
//   register before out_valid rises; one item per cycle is sustained while
//   out_stall is low. in_stall rises only while the queue is full, as when the
//   receiver holds out_stall; a held result keeps its value until taken.
// Reset:
//   rst is synchronous and active high. It empties the queue, returns both
//   parsers to waiting for CR, sets both distances to 2000, the threshold to
//   1000 and the dodge speed to 60. Configuration writes (cfg_write,
//   cfg_index, cfg_data) take effect at once and belong to idle periods.
module tof_ascii_range_obstacle_steer #(
  parameter int QDepth = tars_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tars_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [tars_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [7:0]             lateral_cmd,
  output logic                          obstacle_flag,
  output logic                          left_near,
  output logic                          right_near,
  output logic signed [15:0]            left_distance,
  output logic signed [15:0]            right_distance
);
  import tars_pkg::*;

  logic    accept;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_nonempty;
  cmd_t    front_cmd;
  cmd_t    q_data;
  cfg_wr_t cfg;

  // The queue fill count alone drives stall, so it never looks at in_valid.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  tars_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .action  (action),
    .rx_byte (rx_byte),
    .push    (push),
    .cmd     (front_cmd)
  );

  tars_queue #(
    .QDepth (QDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (front_cmd),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .rdata    (q_data)
  );

  tars_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_nonempty     (q_nonempty),
    .q_data         (q_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .lateral_cmd    (lateral_cmd),
    .obstacle_flag  (obstacle_flag),
    .left_near      (left_near),
    .right_near     (right_near),
    .left_distance  (left_distance),
    .right_distance (right_distance)
  );

endmodule
